// ===== rtl/hbsg_pkg.sv =====
package hbsg_pkg;

   // panel geometry and source store size
   localparam int DST_WIDTH   = 64;
   localparam int DST_HEIGHT  = 32;
   localparam int SCAN_ROWS   = 16;
   localparam int SRC_MAX_DIM = 64;
   localparam int PLANES      = 8;

   // derived widths
   localparam int COL_W     = $clog2(DST_WIDTH + 2);
   localparam int ROW_W     = 5;
   localparam int PLANE_W   = 3;
   localparam int DIM_W     = 7;
   localparam int PIX_W     = 6;
   localparam int Y_W       = ROW_W + 2;
   localparam int PROD_W    = Y_W + DIM_W;
   localparam int MEM_DEPTH = SRC_MAX_DIM * SRC_MAX_DIM;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int DIM_LIM   = (SRC_MAX_DIM < 64) ? SRC_MAX_DIM : 64;

   // stream widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // configuration port
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam bit REG_SRC_WIDTH  = 1'b0;
   localparam bit REG_SRC_HEIGHT = 1'b1;

   // request kinds
   localparam bit REQ_WRITE = 1'b0;
   localparam bit REQ_EMIT  = 1'b1;

   // controller commands to the datapath
   typedef struct packed {
      logic mem_wr;
      logic rd_top;
      logic rd_bot;
      logic load_out;
   } hbsg_cmd_type;

   // datapath status back to the controller
   typedef struct packed {
      logic out_free;
   } hbsg_sts_type;

   // zero counts as one, large values saturate
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
      logic [DIM_W-1:0] res;
      if (raw == '0) begin
         res = DIM_W'(1);
      end else if (raw > DIM_W'(DIM_LIM)) begin
         res = DIM_W'(DIM_LIM);
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

// ===== rtl/hbsg_ctrl.sv =====
module hbsg_ctrl
   import hbsg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_type_bit,
   output logic         req_tready,
   input  hbsg_sts_type sts,
   output hbsg_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TOP  = 2'd1;
   localparam logic [1:0] S_BOT  = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_type_bit == REQ_WRITE)) begin
               cmd.mem_wr = 1'b1;
            end else if (accept) begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            cmd.rd_top = 1'b1;
            state_in   = S_BOT;
         end
         S_BOT: begin
            cmd.rd_bot = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an emitted word only follows a top and a bottom read
   a_load_after_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (state_ff == S_LOAD) && sts.out_free)
      else $error("word loaded outside the load step");
   a_top_then_bot: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_top |=> cmd.rd_bot)
      else $error("bottom read did not follow top read");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_top || cmd.rd_bot) |-> !req_tready)
      else $error("request taken during a fetch");

endmodule

// ===== rtl/hbsg_datapath.sv =====
module hbsg_datapath
   import hbsg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  hbsg_cmd_type          cmd,
   output hbsg_sts_type          sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [DIM_W-1:0]      src_width,
   input  logic [DIM_W-1:0]      src_height,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   // source frame store, undefined until written
   logic [23:0] frame_mem [MEM_DEPTH];
   logic [23:0] rdata_ff;

   // scan position
   logic [ROW_W-1:0]   scan_row_ff;
   logic [ROW_W-1:0]   scan_row_in;
   logic [PLANE_W-1:0] bit_plane_ff;
   logic [PLANE_W-1:0] bit_plane_in;
   logic [COL_W-1:0]   column_pos_ff;
   logic [COL_W-1:0]   column_pos_in;

   // output word register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;
   logic [2:0]            top_bits_ff;

   logic [PIX_W-1:0]  pix_x;
   logic [PIX_W-1:0]  pix_y;
   logic [23:0]       wdata;
   logic [MEM_AW-1:0] waddr;
   logic              wr_in_range;

   logic [DIM_W-1:0]  w_eff;
   logic [DIM_W-1:0]  h_eff;
   logic [Y_W-1:0]    top_y;
   logic [Y_W-1:0]    bot_y;
   logic [Y_W-1:0]    cur_y;
   logic [PROD_W-1:0] x_prod;
   logic [PROD_W-1:0] y_prod;
   logic [PROD_W-1:0] sx;
   logic [PROD_W-1:0] sy;
   logic [MEM_AW-1:0] raddr;
   logic              rd_en;

   logic       is_data;
   logic       is_latch;
   logic       top_vis;
   logic       bot_vis;
   logic       last_row;
   logic       last_plane;
   logic       col_wrap;
   logic [2:0] sel_bits;
   logic [2:0] top_word;
   logic [2:0] bot_word;
   logic [7:0] red_sh;
   logic [7:0] green_sh;
   logic [7:0] blue_sh;

   // request payload unpacking
   assign pix_x = req_tdata[5:0];
   assign pix_y = req_tdata[11:6];
   assign wdata = {req_tdata[19:12], req_tdata[27:20], req_tdata[35:28]};
   assign wr_in_range = ({3'b000, pix_x} < 9'(SRC_MAX_DIM))
                     && ({3'b000, pix_y} < 9'(SRC_MAX_DIM));
   assign waddr = MEM_AW'(MEM_AW'(pix_y) * MEM_AW'(SRC_MAX_DIM)) + MEM_AW'(pix_x);

   // nearest neighbour source address
   assign w_eff  = eff_dim(src_width);
   assign h_eff  = eff_dim(src_height);
   assign top_y  = Y_W'(scan_row_ff);
   assign bot_y  = Y_W'(scan_row_ff) + Y_W'(SCAN_ROWS);
   assign cur_y  = cmd.rd_bot ? bot_y : top_y;
   assign x_prod = PROD_W'(column_pos_ff) * PROD_W'(w_eff);
   assign y_prod = PROD_W'(cur_y) * PROD_W'(h_eff);
   assign sx     = PROD_W'(x_prod / DST_WIDTH);
   assign sy     = PROD_W'(y_prod / DST_HEIGHT);
   assign raddr  = MEM_AW'(MEM_AW'(sy) * MEM_AW'(SRC_MAX_DIM)) + MEM_AW'(sx);
   assign rd_en  = cmd.rd_top || cmd.rd_bot;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && wr_in_range) begin
         frame_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= frame_mem[raddr];
      end
   end

   // word kind and visibility from the scan position
   assign is_data    = column_pos_ff < COL_W'(DST_WIDTH);
   assign is_latch   = column_pos_ff == COL_W'(DST_WIDTH);
   assign top_vis    = top_y < Y_W'(DST_HEIGHT);
   assign bot_vis    = bot_y < Y_W'(DST_HEIGHT);
   assign last_plane = bit_plane_ff == PLANE_W'(PLANES - 1);
   assign last_row   = (Y_W'(scan_row_ff) + Y_W'(1)) >= Y_W'(SCAN_ROWS);
   assign col_wrap   = !(column_pos_ff < COL_W'(DST_WIDTH + 1));

   // current plane bit of each colour
   assign red_sh   = rdata_ff[23:16] >> bit_plane_ff;
   assign green_sh = rdata_ff[15:8] >> bit_plane_ff;
   assign blue_sh  = rdata_ff[7:0] >> bit_plane_ff;
   assign sel_bits = {blue_sh[0], green_sh[0], red_sh[0]};

   always_ff @(posedge clock) begin
      if (cmd.rd_bot) begin
         top_bits_ff <= sel_bits;
      end
   end

   assign top_word = (is_data && top_vis) ? top_bits_ff : 3'b000;
   assign bot_word = (is_data && bot_vis) ? sel_bits : 3'b000;

   // output register
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {3'b000, is_data || is_latch, is_latch, bot_word, top_word,
                         scan_row_ff};
         rsp_last_ff <= col_wrap && last_plane && last_row;
      end
   end

   // scan position advance, column then plane then row
   always_comb begin
      scan_row_in   = scan_row_ff;
      bit_plane_in  = bit_plane_ff;
      column_pos_in = column_pos_ff;
      if (cmd.load_out) begin
         if (!col_wrap) begin
            column_pos_in = column_pos_ff + COL_W'(1);
         end else begin
            column_pos_in = '0;
            if (!last_plane) begin
               bit_plane_in = bit_plane_ff + PLANE_W'(1);
            end else begin
               bit_plane_in = '0;
               scan_row_in  = last_row ? '0 : scan_row_ff + ROW_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff   <= '0;
         bit_plane_ff  <= '0;
         column_pos_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_row_ff   <= scan_row_in;
         bit_plane_ff  <= bit_plane_in;
         column_pos_ff <= column_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      column_pos_ff <= COL_W'(DST_WIDTH + 1))
      else $error("column position past the blank word");
   a_latch_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[11]) |-> rsp_data_ff[12] && (rsp_data_ff[10:5] == '0))
      else $error("latch word carries colour or lacks enable");
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> !rsp_data_ff[12] && !rsp_data_ff[11])
      else $error("frame end on a word that is not blank");

endmodule

// ===== rtl/hub75_scaled_bitplane_generator_top.sv =====
// emit request: top read, bottom read, then load of the drive word once the output register is free
// pixel write: one write per cycle while no emit is in progress, from acceptance to load
// an emit uses the single read port of the frame store twice, for top then bottom
// a drive word waits in the output register while the next pixel write is taken
// synchronous reset clears the scan position and output valid, sets source size 64 x 64
// reset leaves the frame store as it is: entries are undefined until written
module hub75_scaled_bitplane_generator_top
   import hbsg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pix_x[5:0], pix_y[11:6], red_in[19:12], green_in[27:20], blue_in[35:28], zero[39:36]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                  req_tuser,
   // drive word stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // row_addr[4:0], red_top[5], green_top[6], blue_top[7], red_bottom[8],
   // green_bottom[9], blue_bottom[10], latch[11], output_enable[12], zero[15:13]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // frame_end
   output logic                  rsp_tlast,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AW-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready
);

   logic [DIM_W-1:0] src_width_ff;
   logic [DIM_W-1:0] src_width_in;
   logic [DIM_W-1:0] src_height_ff;
   logic [DIM_W-1:0] src_height_in;
   logic             csr_wr;
   hbsg_cmd_type     cmd;
   hbsg_sts_type     sts;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_SRC_WIDTH:  src_width_in  = csr_pwdata[DIM_W-1:0];
            REG_SRC_HEIGHT: src_height_in = csr_pwdata[DIM_W-1:0];
            default: begin
               src_width_in = src_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_W'(64);
         src_height_ff <= DIM_W'(64);
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr[2])
         REG_SRC_WIDTH:  csr_prdata = CSR_DW'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = CSR_DW'(src_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   hbsg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_type_bit (req_tuser),
      .req_tready   (req_tready),
      .sts          (sts),
      .cmd          (cmd)
   );

   hbsg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
